FILE: src/cafr_pkg.sv
`default_nettype none

package cafr_pkg;

  localparam int unsigned ChunkMax   = 7;
  localparam int unsigned FillW      = 3;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] PosAddr = 2'd0;
  localparam logic [1:0] PosFunc = 2'd1;
  localparam logic [1:0] PosData = 2'd2;

  localparam logic [7:0] ByteA   = 8'h41;
  localparam logic [7:0] ByteT   = 8'h54;
  localparam logic [7:0] ByteCr  = 8'h0d;
  localparam logic [7:0] ByteLf  = 8'h0a;
  localparam logic [2:0] ExtFlag = 3'b100;

  // Output byte positions inside a frame
  localparam logic [IdxW-1:0] IdxA     = 5'd0;
  localparam logic [IdxW-1:0] IdxT     = 5'd1;
  localparam logic [IdxW-1:0] IdxHdr3  = 5'd2;
  localparam logic [IdxW-1:0] IdxHdr2  = 5'd3;
  localparam logic [IdxW-1:0] IdxHdr1  = 5'd4;
  localparam logic [IdxW-1:0] IdxHdr0  = 5'd5;
  localparam logic [IdxW-1:0] IdxLen   = 5'd6;
  localparam logic [IdxW-1:0] IdxFunc  = 5'd7;
  localparam logic [IdxW-1:0] IdxData  = 5'd8;
  localparam logic [IdxW-1:0] IdxLfOfs = 5'd9;

  typedef logic [ChunkMax-1:0][7:0] chunk_t;

  typedef struct packed {
    logic             is_err;
    logic [7:0]       addr;
    logic [7:0]       pkt;
    logic [FillW-1:0] fill;
    logic [7:0]       func;
    chunk_t           data;
  } job_t;

endpackage

`default_nettype wire

FILE: src/cafr_in_if.sv
`default_nettype none

interface cafr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       end_of_command;

  modport source (output valid, output cmd_byte, output end_of_command, input ready);
  modport sink (input valid, input cmd_byte, input end_of_command, output ready);
endinterface

`default_nettype wire

FILE: src/cafr_out_if.sv
`default_nettype none

interface cafr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       run_last;
  logic       status;

  modport source (output valid, output frame_byte, output run_last, output status, input ready);
  modport sink (input valid, input frame_byte, input run_last, input status, output ready);
endinterface

`default_nettype wire

FILE: src/cafr_front.sv
`default_nettype none

module cafr_front
  import cafr_pkg::*;
#(
  parameter int unsigned CHUNK_BYTES = 7
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cafr_in_if.sink    in_i,
  input  wire logic  q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [1:0]       pos_q, pos_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       func_q, func_d;
  logic [7:0]       pkt_q, pkt_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] fill_inc;
  chunk_t           store_q, store_d;
  logic             accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign fill_inc   = fill_q + FillW'(1);

  always_comb begin
    pos_d   = pos_q;
    addr_d  = addr_q;
    func_d  = func_q;
    pkt_d   = pkt_q;
    fill_d  = fill_q;
    store_d = store_q;
    push_o  = 1'b0;
    job_o   = '{is_err: 1'b0, addr: addr_q, pkt: pkt_q, fill: fill_q,
                func: func_q, data: store_q};
    unique case (pos_q)
      PosFunc: begin
        func_d = in_i.cmd_byte;
        pkt_d  = '0;
        fill_d = '0;
        if (in_i.end_of_command) begin
          // Function code alone: one frame with an empty chunk
          push_o     = accept;
          job_o.pkt  = '0;
          job_o.fill = '0;
          job_o.func = in_i.cmd_byte;
          pkt_d      = 8'd1;
          pos_d      = PosAddr;
        end else begin
          pos_d = PosData;
        end
      end
      PosData: begin
        if (fill_q < FillW'(ChunkMax)) begin
          store_d[fill_q] = in_i.cmd_byte;
        end
        fill_d = fill_inc;
        if (in_i.end_of_command || fill_inc >= FillW'(CHUNK_BYTES)) begin
          push_o     = accept;
          job_o.fill = fill_inc;
          job_o.data = store_d;
          pkt_d      = pkt_q + 8'd1;
          fill_d     = '0;
        end
        if (in_i.end_of_command) begin
          pos_d = PosAddr;
        end
      end
      default: begin
        addr_d = in_i.cmd_byte;
        if (in_i.end_of_command) begin
          push_o       = accept;
          job_o.is_err = 1'b1;
          pos_d        = PosAddr;
        end else begin
          pos_d = PosFunc;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosAddr;
      addr_q <= '0;
      func_q <= '0;
      pkt_q  <= '0;
      fill_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      addr_q <= addr_d;
      func_q <= func_d;
      pkt_q  <= pkt_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q <= store_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/cafr_queue.sv
`default_nettype none

module cafr_queue
  import cafr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire job_t  job_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       head_valid_o,
  output job_t       head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/cafr_back.sv
`default_nettype none

module cafr_back
  import cafr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  wire job_t  head_i,
  output logic       pop_o,
  cafr_out_if.source out_o
);

  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  lf_idx;
  logic [IdxW-1:0]  data_ofs;
  logic [FillW-1:0] data_sel;
  logic [18:0]      hdr;
  logic [7:0]       byte_sel;
  logic             last;
  logic             step;
  logic             ov_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             stat_q;

  assign hdr      = {head_i.addr, head_i.pkt, ExtFlag};
  assign lf_idx   = IdxW'(head_i.fill) + IdxLfOfs;
  assign data_ofs = idx_q - IdxData;
  assign data_sel = data_ofs[FillW-1:0];
  assign last     = head_i.is_err || (idx_q == lf_idx);
  assign step     = head_valid_i && (!ov_q || out_o.ready);
  assign pop_o    = step && last;

  always_comb begin
    if (head_i.is_err) begin
      byte_sel = '0;
    end else if (idx_q == IdxA) begin
      byte_sel = ByteA;
    end else if (idx_q == IdxT) begin
      byte_sel = ByteT;
    end else if (idx_q == IdxHdr3) begin
      byte_sel = '0;
    end else if (idx_q == IdxHdr2) begin
      byte_sel = {5'd0, hdr[18:16]};
    end else if (idx_q == IdxHdr1) begin
      byte_sel = hdr[15:8];
    end else if (idx_q == IdxHdr0) begin
      byte_sel = hdr[7:0];
    end else if (idx_q == IdxLen) begin
      byte_sel = 8'(head_i.fill) + 8'd1;
    end else if (idx_q == IdxFunc) begin
      byte_sel = head_i.func;
    end else if (idx_q == lf_idx) begin
      byte_sel = ByteLf;
    end else if (idx_q == lf_idx - IdxW'(1)) begin
      byte_sel = ByteCr;
    end else if (data_sel < FillW'(ChunkMax)) begin
      byte_sel = head_i.data[data_sel];
    end else begin
      byte_sel = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else if (step) begin
      ov_q  <= 1'b1;
      idx_q <= last ? '0 : idx_q + IdxW'(1);
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  // Hold the payload while the sink stalls
  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q <= byte_sel;
      last_q <= last;
      stat_q <= head_i.is_err;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.frame_byte = byte_q;
  assign out_o.run_last   = last_q;
  assign out_o.status     = stat_q;

endmodule

`default_nettype wire

FILE: src/command_to_at_can_framer.sv
`default_nettype none

// Motor command to serial-to-CAN bridge framer. Command bytes (address, function code,
// payload, last byte flagged) are taken at up to one per cycle while the two-entry frame
// queue has room; every CHUNK_BYTES payload bytes, or the end of the command, closes one
// frame. The output serializer sends one byte per cycle while a frame is queued and the
// sink is ready; a frame carrying n payload bytes is n + 10 bytes long ('A', 'T', four
// header bytes, length, function code, payload, CR, LF); an address-only command yields
// one error transfer with status set. Sustained throughput is set by that serializer:
// full chunks send 17 output bytes per 7 payload bytes.

module command_to_at_can_framer
  import cafr_pkg::*;
#(
  parameter int unsigned CHUNK_BYTES = 7
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cafr_in_if.sink    in_i,
  cafr_out_if.source out_o
);

  logic push;
  logic pop;
  logic q_full;
  logic head_valid;
  job_t job;
  job_t head;

  cafr_front #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job)
  );

  cafr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  cafr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
